@@ hw/rtl/xfsc_pkg.sv @@
// Shared types and constants for the XOR float stream compressor.
// Used by the encoder, the byte serializer and the top level; depends on nothing.
package xfsc_pkg;

	localparam int WordBits  = 64;
	localparam int CountBits = 6;
	localparam int HdrBits   = 14;
	localparam int CodeBits  = HdrBits + WordBits;
	localparam int BufBytes  = 11;
	localparam int BufBits   = 8 * BufBytes;
	localparam int NumBits   = 4;

	// Encoder state that persists from one item to the next.
	typedef struct packed {
		logic [WordBits-1:0]  prev;
		logic                 first_pending;
		logic                 window_valid;
		logic [CountBits-1:0] window_leading;
		logic [CountBits-1:0] window_trailing;
		logic [7:0]           pbits;   // leftover bits, left aligned
		logic [2:0]           pcount;
	} enc_state_t;

	// Bytes produced by one item, first byte in the top eight bits.
	typedef struct packed {
		logic [BufBits-1:0] data;
		logic [NumBits-1:0] nbytes;
		logic               last;
	} byte_group_t;

endpackage

@@ hw/rtl/xfsc_encoder.sv @@
// Combinational encoder: one value against the stored state gives its bytes and
// the next state. Depends on xfsc_pkg.
module xfsc_encoder (
	input  logic [xfsc_pkg::WordBits-1:0] value,
	input  logic                          eos,
	input  xfsc_pkg::enc_state_t          state,
	output xfsc_pkg::enc_state_t          state_next,
	output xfsc_pkg::byte_group_t         group
);

	localparam int WB = xfsc_pkg::WordBits;
	localparam int CB = xfsc_pkg::CountBits;
	localparam int HB = xfsc_pkg::HdrBits;
	localparam int KB = xfsc_pkg::CodeBits;
	localparam int BB = xfsc_pkg::BufBits;

	// Leading zeros by halving steps; the input is known to be nonzero.
	function automatic logic [CB-1:0] lead_zeros(input logic [WB-1:0] x);
		logic [WB-1:0] v;
		logic [CB-1:0] n;
		v = x;
		n = '0;
		if (v[63:32] == '0) begin n[5] = 1'b1; v = v << 32; end
		if (v[63:48] == '0) begin n[4] = 1'b1; v = v << 16; end
		if (v[63:56] == '0) begin n[3] = 1'b1; v = v << 8;  end
		if (v[63:60] == '0) begin n[2] = 1'b1; v = v << 4;  end
		if (v[63:62] == '0) begin n[1] = 1'b1; v = v << 2;  end
		if (v[63] == 1'b0) begin n[0] = 1'b1; end
		return n;
	endfunction

	function automatic logic [CB-1:0] trail_zeros(input logic [WB-1:0] x);
		logic [WB-1:0] v;
		logic [CB-1:0] n;
		v = x;
		n = '0;
		if (v[31:0] == '0) begin n[5] = 1'b1; v = v >> 32; end
		if (v[15:0] == '0) begin n[4] = 1'b1; v = v >> 16; end
		if (v[7:0] == '0)  begin n[3] = 1'b1; v = v >> 8;  end
		if (v[3:0] == '0)  begin n[2] = 1'b1; v = v >> 4;  end
		if (v[1:0] == '0)  begin n[1] = 1'b1; v = v >> 2;  end
		if (v[0] == 1'b0)  begin n[0] = 1'b1; end
		return n;
	endfunction

	logic [WB-1:0] x;
	logic [CB-1:0] lz, tz, lead, trail;
	logic          use_window;
	logic [6:0]    mlen;
	logic [HB-1:0] hdr;
	logic [3:0]    hlen;
	logic [WB-1:0] body;
	logic [KB-1:0] code;
	logic [6:0]    ncode;
	logic [6:0]    total;
	logic [BB-1:0] bits;
	logic [BB-1:0] rest;
	logic [3:0]    full;

	always_comb begin
		x          = value ^ state.prev;
		lz         = lead_zeros(x);
		tz         = trail_zeros(x);
		use_window = state.window_valid && (lz >= state.window_leading)
			&& (tz >= state.window_trailing);
		lead  = use_window ? state.window_leading : lz;
		trail = use_window ? state.window_trailing : tz;
		mlen  = 7'd64 - {1'b0, lead} - {1'b0, trail};

		state_next = state;
		state_next.prev = value;
		state_next.first_pending = 1'b0;

		// Shifting the XOR left by the leading count leaves the meaningful bits
		// left aligned with zeros behind them, in both the window and explicit code.
		if (state.first_pending) begin
			hdr  = '0;
			hlen = 4'd0;
			body = value;
			ncode = 7'd64;
		end else if (x == '0) begin
			hdr  = '0;
			hlen = 4'd1;
			body = '0;
			ncode = 7'd1;
		end else if (use_window) begin
			hdr  = {2'b10, {(HB-2){1'b0}}};
			hlen = 4'd2;
			body = x << lead;
			ncode = mlen + 7'd2;
		end else begin
			hdr  = {2'b11, lz, mlen[CB-1:0]};
			hlen = 4'd14;
			body = x << lead;
			ncode = mlen + 7'd14;
			state_next.window_valid    = 1'b1;
			state_next.window_leading  = lz;
			state_next.window_trailing = tz;
		end

		code  = {hdr, {WB{1'b0}}} | ({{HB{1'b0}}, body} << (4'd14 - hlen));
		total = {4'b0, state.pcount} + ncode;
		bits  = {state.pbits, {(BB-8){1'b0}}}
			| ({code, {(BB-KB){1'b0}}} >> state.pcount);
		full  = total[6:3];
		rest  = bits << {full, 3'b000};

		group.data   = bits;
		group.last   = eos;
		group.nbytes = full + {3'b000, eos && (total[2:0] != 3'd0)};

		state_next.pbits  = rest[BB-1 -: 8];
		state_next.pcount = total[2:0];

		// End of stream pads the last byte and puts everything back to reset.
		if (eos) begin
			state_next.prev            = '0;
			state_next.first_pending   = 1'b1;
			state_next.window_valid    = 1'b0;
			state_next.window_leading  = '0;
			state_next.window_trailing = '0;
			state_next.pbits           = '0;
			state_next.pcount          = '0;
		end
	end

endmodule

@@ hw/rtl/xfsc_serializer.sv @@
// Output register that holds one item's bytes and hands them out one per cycle while out_ready is high.
// Depends on xfsc_pkg.
module xfsc_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  xfsc_pkg::byte_group_t group,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  stream_last
);

	localparam int BB = xfsc_pkg::BufBits;
	localparam int NB = xfsc_pkg::NumBits;

	logic [BB-1:0] data_s2;
	logic [NB-1:0] cnt_s2;
	logic          last_s2;
	logic          valid_s2;
	logic          take;

	assign take        = valid_s2 && out_ready;
	assign free        = !valid_s2 || (take && (cnt_s2 == NB'(1)));
	assign out_valid   = valid_s2;
	assign out_byte    = data_s2[BB-1 -: 8];
	assign stream_last = last_s2 && (cnt_s2 == NB'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			cnt_s2   <= group.nbytes;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - NB'(1);
			if (cnt_s2 == NB'(1)) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= group.data;
			last_s2 <= group.last;
		end else if (take) begin
			data_s2 <= data_s2 << 8;
		end
	end

endmodule

@@ hw/rtl/xor_float_stream_compressor.sv @@
// Top level of the XOR float stream compressor: input register, encoder state
// and byte serializer. Depends on xfsc_pkg, xfsc_encoder and xfsc_serializer.
//
// The block takes one 64-bit double bit pattern per item and packs it into an
// MSB-first byte stream. The first value of a stream goes out as 64 raw bits;
// each later value is XORed with its predecessor and coded as a single 0 bit,
// as 10 plus the bits inside the stored leading/trailing window, or as 11, a
// 6-bit leading zero count, a 6-bit length (64 coded as 0) and the meaningful
// bits. An item with end_of_stream set zero-pads the last byte, marks that byte
// with stream_last and returns the block to its reset state. The encoding is
// done from the input register into an output buffer, which hands out one
// byte per cycle while out_ready is high. An item completes 0 to 11 bytes, at
// most 10 in mid-stream; one that completes no byte leaves without using the
// output buffer. A new item is taken every cycle that the output buffer can
// absorb it, including the cycle in which the previous item's last byte is
// taken.
module xor_float_stream_compressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value_bits,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        stream_last
);

	logic [63:0] value_s1;
	logic        eos_s1;
	logic        valid_s1;

	xfsc_pkg::enc_state_t  state_q;
	xfsc_pkg::enc_state_t  state_next;
	xfsc_pkg::byte_group_t group;

	logic ser_free;
	logic advance;
	logic load;

	xfsc_encoder u_encoder (
		.value      (value_s1),
		.eos        (eos_s1),
		.state      (state_q),
		.state_next (state_next),
		.group      (group)
	);

	// An item that completes no byte leaves without touching the serializer.
	assign advance  = valid_s1 && (ser_free || (group.nbytes == '0));
	assign load     = advance && (group.nbytes != '0);
	assign in_ready = !valid_s1 || advance;

	xfsc_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.group       (group),
		.free        (ser_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.stream_last (stream_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s1 <= value_bits;
			eos_s1   <= end_of_stream;
		end
	end

	// The coding state moves on only when the item in the input register leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev            <= '0;
			state_q.first_pending   <= 1'b1;
			state_q.window_valid    <= 1'b0;
			state_q.window_leading  <= '0;
			state_q.window_trailing <= '0;
			state_q.pbits           <= '0;
			state_q.pcount          <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

endmodule
